// File: rtl/gaps_pkg.sv
`default_nettype none

package gaps_pkg;

    // Default storage size of the grid
    localparam int MAX_COLS_DEF = 32;
    localparam int MAX_ROWS_DEF = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_START_COL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd5;

    // Item modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_WRITTEN = 3'd0;
    localparam logic [2:0] ST_FOUND   = 3'd1;
    localparam logic [2:0] ST_NOPATH  = 3'd2;
    localparam logic [2:0] ST_POINT   = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] cell_col;
        logic [4:0] cell_row;
        logic       passable;
        logic [9:0] point_index;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] point_count;
        logic [4:0]  point_col;
        logic [4:0]  point_row;
    } out_word_t;

endpackage

`default_nettype wire

// File: rtl/grid_astar_path_search_top.sv
// A* path search over a wrapping grid with four neighbors per cell.
// Channels: input words (in_valid / in_stall / in_data) and result words
// (out_valid / out_stall / out_data); a word moves when valid is high and
// stall is low. Configuration registers are written through cfg_valid /
// cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// A cell write and a path point read present their result in the cycle
// after the accept edge; a read past the path end, and a search with start
// equal to goal, present it at the accept edge itself. A search sweeps the
// cell memory, then per expanded cell reads and weighs each neighbor, makes
// one pass over the open list to pick the best entry, one pass to close
// the gap it leaves, and reads and writes the cell to close it; a cost
// decrease adds a pass over the open list. The trace back reads the parent
// of each path point.
// All of this is set by the single cell memory and the single list memory,
// each giving one read and one write per cycle.
// One item is worked at a time; in_stall stays high while it runs.
// After reset the cell memory is cleared in a pass over all MAX_COLS*MAX_ROWS
// cells, during which no item is accepted (configuration writes are).
// A result waits in the output register while out_stall is high; the next
// item is accepted once that register drains.
`default_nettype none

module grid_astar_path_search_top #(
    parameter int MAX_COLS = gaps_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = gaps_pkg::MAX_ROWS_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  gaps_pkg::in_word_t                 in_data,
    output logic                               out_valid,
    input  wire                                out_stall,
    output gaps_pkg::out_word_t                out_data,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [gaps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [gaps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CB  = $clog2(MAX_COLS);
    localparam int RB  = $clog2(MAX_ROWS);
    localparam int XW0 = (CB > RB) ? CB : RB;
    localparam int XW  = (XW0 > 5) ? XW0 : 5;
    localparam int DW  = XW + 1;
    localparam int NC  = MAX_COLS * MAX_ROWS;
    localparam int AW  = $clog2(NC);
    localparam int GW  = AW + 1;
    localparam int SW  = ((GW > XW) ? GW : XW) + 1;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WCELL = 4'd2;
    localparam logic [3:0] S_RDPT  = 4'd3;
    localparam logic [3:0] S_CLR   = 4'd4;
    localparam logic [3:0] S_EXRD  = 4'd5;
    localparam logic [3:0] S_EXEV  = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_SCAN0 = 4'd8;
    localparam logic [3:0] S_SCAN  = 4'd9;
    localparam logic [3:0] S_PICK  = 4'd10;
    localparam logic [3:0] S_SHIFT = 4'd11;
    localparam logic [3:0] S_CLRD  = 4'd12;
    localparam logic [3:0] S_CLWR  = 4'd13;
    localparam logic [3:0] S_TRWR  = 4'd14;
    localparam logic [3:0] S_TRRD  = 4'd15;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef struct packed {
        logic          walk;
        logic          closed;
        logic          open;
        logic [GW-1:0] cost;
        logic [XW-1:0] pcol;
        logic [XW-1:0] prow;
    } cell_ent_t;

    typedef struct packed {
        logic [XW-1:0] col;
        logic [XW-1:0] row;
        logic [SW-1:0] score;
    } list_ent_t;

    function automatic logic [AW-1:0] cell_idx(input logic [XW-1:0] col,
                                               input logic [XW-1:0] row);
        return AW'(int'(row) * MAX_COLS + int'(col));
    endfunction

    // Configuration registers
    logic [4:0] start_col_reg, start_row_reg, goal_col_reg, goal_row_reg;
    logic [5:0] grid_width_reg, grid_height_reg;

    // Control and working registers
    logic [3:0]          state_reg, state_next;
    logic [GW-1:0]       k_reg, k_next;
    logic [GW-1:0]       cnt_reg, cnt_next;
    logic [GW-1:0]       len_reg, len_next;
    logic [1:0]          dir_reg, dir_next;
    logic [GW-1:0]       g_reg, g_next;
    logic [XW-1:0]       cur_col_reg, cur_col_next, cur_row_reg, cur_row_next;
    logic [GW-1:0]       best_k_reg, best_k_next;
    logic [SW-1:0]       best_score_reg, best_score_next;
    logic [XW-1:0]       best_col_reg, best_col_next, best_row_reg, best_row_next;
    gaps_pkg::in_word_t  item_reg, item_next;
    logic                out_valid_reg;
    gaps_pkg::out_word_t out_reg, out_next;
    logic                out_load;
    logic                nb_done;

    // Memory ports
    cell_ent_t           cell_mem [NC];
    cell_ent_t           cm_rdata_reg, cm_wdata;
    logic                cm_re, cm_we;
    logic [AW-1:0]       cm_raddr, cm_waddr;
    list_ent_t           list_mem [NC];
    list_ent_t           lm_rdata_reg, lm_wdata;
    logic                lm_re, lm_we;
    logic [AW-1:0]       lm_raddr, lm_waddr;

    // Derived values
    logic                in_acc;
    logic [DW-1:0]       w_eff, h_eff;
    logic [XW-1:0]       start_c, start_r, goal_c, goal_r;
    logic [AW-1:0]       start_idx;
    logic                start_in;
    logic                wr_ok;
    logic [DW-1:0]       cval, rval;
    logic                cneg, rneg;
    logic [XW-1:0]       nb_col, nb_row;
    logic [AW-1:0]       nb_idx;
    logic [GW-1:0]       ng;
    logic [XW-1:0]       dc, dr;
    logic [XW:0]         hsum;
    logic [SW-1:0]       nscore;
    logic                pi_ok;
    logic [AW-1:0]       pt_addr;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // Clamp the grid size to the storage
    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = DW'(1);
        else if (int'(grid_width_reg) > MAX_COLS)
            w_eff = DW'(MAX_COLS);
        else
            w_eff = DW'(grid_width_reg);
        if (grid_height_reg == '0)
            h_eff = DW'(1);
        else if (int'(grid_height_reg) > MAX_ROWS)
            h_eff = DW'(MAX_ROWS);
        else
            h_eff = DW'(grid_height_reg);
    end

    assign start_c   = XW'(start_col_reg);
    assign start_r   = XW'(start_row_reg);
    assign goal_c    = XW'(goal_col_reg);
    assign goal_r    = XW'(goal_row_reg);
    assign start_idx = cell_idx(start_c, start_r);
    assign start_in  = (DW'(start_c) < w_eff) && (DW'(start_r) < h_eff);
    assign wr_ok     = (int'(item_reg.cell_col) < MAX_COLS) &&
                       (int'(item_reg.cell_row) < MAX_ROWS);
    assign pi_ok     = int'(in_data.point_index) < int'(len_reg);
    assign pt_addr   = AW'(int'(len_reg) - 1 - int'(in_data.point_index));

    // Step to the neighbor in the current direction, wrapping at the edges
    always_comb
    begin
        cval = {1'b0, cur_col_reg};
        rval = {1'b0, cur_row_reg};
        cneg = 1'b0;
        rneg = 1'b0;
        case (dir_reg)
            DIR_LEFT:
            begin
                if (cur_col_reg == '0)
                    cneg = 1'b1;
                else
                    cval = cval - 1'b1;
            end
            DIR_RIGHT: cval = cval + 1'b1;
            DIR_UP:
            begin
                if (cur_row_reg == '0)
                    rneg = 1'b1;
                else
                    rval = rval - 1'b1;
            end
            default: rval = rval + 1'b1;
        endcase
        nb_col = cneg ? XW'(w_eff - 1'b1) : ((cval >= w_eff) ? '0 : cval[XW-1:0]);
        nb_row = rneg ? XW'(h_eff - 1'b1) : ((rval >= h_eff) ? '0 : rval[XW-1:0]);
    end

    // Neighbor cost and score
    assign nb_idx = cell_idx(nb_col, nb_row);
    assign ng     = GW'(g_reg + 1'b1);
    assign dc     = (nb_col > goal_c) ? (nb_col - goal_c) : (goal_c - nb_col);
    assign dr     = (nb_row > goal_r) ? (nb_row - goal_r) : (goal_r - nb_row);
    assign hsum   = {1'b0, dc} + {1'b0, dr};
    assign nscore = SW'(ng) + SW'(hsum[XW:1]);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        dir_next        = dir_reg;
        g_next          = g_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        best_k_next     = best_k_reg;
        best_score_next = best_score_reg;
        best_col_next   = best_col_reg;
        best_row_next   = best_row_reg;
        item_next       = item_reg;
        cm_re           = 1'b0;
        cm_raddr        = '0;
        cm_we           = 1'b0;
        cm_waddr        = '0;
        cm_wdata        = cm_rdata_reg;
        lm_re           = 1'b0;
        lm_raddr        = '0;
        lm_we           = 1'b0;
        lm_waddr        = '0;
        lm_wdata        = lm_rdata_reg;
        out_load        = 1'b0;
        out_next        = '0;
        nb_done         = 1'b0;

        case (state_reg)
            // Clear the cell memory after reset
            S_INIT:
            begin
                cm_we    = 1'b1;
                cm_waddr = k_reg[AW-1:0];
                cm_wdata = '0;
                if (k_reg == GW'(NC - 1))
                begin
                    k_next     = '0;
                    state_next = S_IDLE;
                end
                else
                    k_next = k_reg + 1'b1;
            end

            // Take a word and dispatch on its mode
            S_IDLE:
            begin
                if (in_acc)
                begin
                    item_next = in_data;
                    case (in_data.mode)
                        gaps_pkg::MODE_WRITE:
                        begin
                            cm_re      = 1'b1;
                            cm_raddr   = cell_idx(XW'(in_data.cell_col),
                                                  XW'(in_data.cell_row));
                            state_next = S_WCELL;
                        end
                        gaps_pkg::MODE_SEARCH:
                        begin
                            len_next = '0;
                            if (start_col_reg == goal_col_reg &&
                                start_row_reg == goal_row_reg)
                            begin
                                out_load        = 1'b1;
                                out_next.status = gaps_pkg::ST_NOPATH;
                            end
                            else
                            begin
                                k_next     = '0;
                                state_next = S_CLR;
                            end
                        end
                        gaps_pkg::MODE_READ:
                        begin
                            out_next.point_count = 11'(len_reg);
                            if (pi_ok)
                            begin
                                lm_re      = 1'b1;
                                lm_raddr   = pt_addr;
                                state_next = S_RDPT;
                            end
                            else
                            begin
                                out_load        = 1'b1;
                                out_next.status = gaps_pkg::ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Merge the passable bit into the cell entry
            S_WCELL:
            begin
                cm_we         = wr_ok;
                cm_waddr      = cell_idx(XW'(item_reg.cell_col), XW'(item_reg.cell_row));
                cm_wdata.walk = item_reg.passable;
                out_load        = 1'b1;
                out_next.status = gaps_pkg::ST_WRITTEN;
                state_next      = S_IDLE;
            end

            // Return the requested path point
            S_RDPT:
            begin
                out_load             = 1'b1;
                out_next.status      = gaps_pkg::ST_POINT;
                out_next.point_count = 11'(len_reg);
                out_next.point_col   = lm_rdata_reg.col[4:0];
                out_next.point_row   = lm_rdata_reg.row[4:0];
                state_next           = S_IDLE;
            end

            // Sweep open and closed marks, closing the start cell on the way
            S_CLR:
            begin
                if (k_reg < GW'(NC))
                begin
                    cm_re    = 1'b1;
                    cm_raddr = k_reg[AW-1:0];
                end
                if (k_reg != '0)
                begin
                    cm_we           = 1'b1;
                    cm_waddr        = AW'(k_reg - 1'b1);
                    cm_wdata.open   = 1'b0;
                    cm_wdata.closed = start_in && (AW'(k_reg - 1'b1) == start_idx);
                end
                if (k_reg == GW'(NC))
                begin
                    cnt_next     = '0;
                    cur_col_next = start_c;
                    cur_row_next = start_r;
                    g_next       = '0;
                    dir_next     = DIR_LEFT;
                    state_next   = S_EXRD;
                end
                else
                    k_next = k_reg + 1'b1;
            end

            // Fetch the neighbor's entry
            S_EXRD:
            begin
                cm_re      = 1'b1;
                cm_raddr   = nb_idx;
                state_next = S_EXEV;
            end

            // Open the neighbor, or lower its cost
            S_EXEV:
            begin
                if (!cm_rdata_reg.walk || cm_rdata_reg.closed)
                    nb_done = 1'b1;
                else if (!cm_rdata_reg.open)
                begin
                    if (cnt_reg < GW'(NC))
                    begin
                        cm_we          = 1'b1;
                        cm_waddr       = nb_idx;
                        cm_wdata.open  = 1'b1;
                        cm_wdata.cost  = ng;
                        cm_wdata.pcol  = cur_col_reg;
                        cm_wdata.prow  = cur_row_reg;
                        lm_we          = 1'b1;
                        lm_waddr       = cnt_reg[AW-1:0];
                        lm_wdata.col   = nb_col;
                        lm_wdata.row   = nb_row;
                        lm_wdata.score = nscore;
                        cnt_next       = cnt_reg + 1'b1;
                    end
                    nb_done = 1'b1;
                end
                else if (ng < cm_rdata_reg.cost)
                begin
                    cm_we         = 1'b1;
                    cm_waddr      = nb_idx;
                    cm_wdata.cost = ng;
                    cm_wdata.pcol = cur_col_reg;
                    cm_wdata.prow = cur_row_reg;
                    k_next        = '0;
                    state_next    = S_UPD;
                end
                else
                    nb_done = 1'b1;
            end

            // Rewrite the score of the neighbor's open list entry
            S_UPD:
            begin
                if (k_reg < cnt_reg)
                begin
                    lm_re    = 1'b1;
                    lm_raddr = k_reg[AW-1:0];
                end
                if (k_reg != '0 && lm_rdata_reg.col == nb_col &&
                    lm_rdata_reg.row == nb_row)
                begin
                    lm_we          = 1'b1;
                    lm_waddr       = AW'(k_reg - 1'b1);
                    lm_wdata.score = nscore;
                end
                if (k_reg == cnt_reg)
                    nb_done = 1'b1;
                else
                    k_next = k_reg + 1'b1;
            end

            // Give up on an empty open list
            S_SCAN0:
            begin
                if (cnt_reg == '0)
                begin
                    out_load        = 1'b1;
                    out_next.status = gaps_pkg::ST_NOPATH;
                    state_next      = S_IDLE;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_SCAN;
                end
            end

            // Find the earliest entry with the lowest score
            S_SCAN:
            begin
                if (k_reg < cnt_reg)
                begin
                    lm_re    = 1'b1;
                    lm_raddr = k_reg[AW-1:0];
                end
                if (k_reg != '0 &&
                    (k_reg == GW'(1) || lm_rdata_reg.score < best_score_reg))
                begin
                    best_k_next     = k_reg - 1'b1;
                    best_score_next = lm_rdata_reg.score;
                    best_col_next   = lm_rdata_reg.col;
                    best_row_next   = lm_rdata_reg.row;
                end
                if (k_reg == cnt_reg)
                    state_next = S_PICK;
                else
                    k_next = k_reg + 1'b1;
            end

            // Stop at the goal, else drop the best entry
            S_PICK:
            begin
                if (best_col_reg == goal_c && best_row_reg == goal_r)
                begin
                    cur_col_next = goal_c;
                    cur_row_next = goal_r;
                    k_next       = '0;
                    state_next   = S_TRWR;
                end
                else
                begin
                    k_next     = best_k_reg + 1'b1;
                    state_next = S_SHIFT;
                end
            end

            // Move the later entries down by one
            S_SHIFT:
            begin
                if (k_reg < cnt_reg)
                begin
                    lm_re    = 1'b1;
                    lm_raddr = k_reg[AW-1:0];
                end
                if (k_reg > GW'(best_k_reg + 1'b1))
                begin
                    lm_we    = 1'b1;
                    lm_waddr = AW'(k_reg - 2'd2);
                end
                if (k_reg == cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_CLRD;
                end
                else
                    k_next = k_reg + 1'b1;
            end

            // Close the best cell and expand it
            S_CLRD:
            begin
                cm_re      = 1'b1;
                cm_raddr   = cell_idx(best_col_reg, best_row_reg);
                state_next = S_CLWR;
            end

            S_CLWR:
            begin
                cm_we           = 1'b1;
                cm_waddr        = cell_idx(best_col_reg, best_row_reg);
                cm_wdata.open   = 1'b0;
                cm_wdata.closed = 1'b1;
                g_next          = cm_rdata_reg.cost;
                cur_col_next    = best_col_reg;
                cur_row_next    = best_row_reg;
                dir_next        = DIR_LEFT;
                state_next      = S_EXRD;
            end

            // Record the path from the goal back to the start
            S_TRWR:
            begin
                lm_we        = 1'b1;
                lm_waddr     = k_reg[AW-1:0];
                lm_wdata     = '0;
                lm_wdata.col = cur_col_reg;
                lm_wdata.row = cur_row_reg;
                k_next       = k_reg + 1'b1;
                if (cur_col_reg == start_c && cur_row_reg == start_r)
                begin
                    len_next             = GW'(k_reg + 1'b1);
                    out_load             = 1'b1;
                    out_next.status      = gaps_pkg::ST_FOUND;
                    out_next.point_count = 11'(k_reg + 1'b1);
                    state_next           = S_IDLE;
                end
                else
                begin
                    cm_re      = 1'b1;
                    cm_raddr   = cell_idx(cur_col_reg, cur_row_reg);
                    state_next = S_TRRD;
                end
            end

            S_TRRD:
            begin
                cur_col_next = cm_rdata_reg.pcol;
                cur_row_next = cm_rdata_reg.prow;
                state_next   = S_TRWR;
            end

            default: state_next = S_IDLE;
        endcase

        // Advance to the next neighbor, or pick again after the last one
        if (nb_done)
        begin
            if (dir_reg == DIR_DOWN)
                state_next = S_SCAN0;
            else
            begin
                dir_next   = dir_reg + 1'b1;
                state_next = S_EXRD;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            k_reg         <= '0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            dir_reg       <= DIR_LEFT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            dir_reg   <= dir_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_col_reg   <= '0;
            start_row_reg   <= '0;
            goal_col_reg    <= '0;
            goal_row_reg    <= '0;
            grid_width_reg  <= 6'd32;
            grid_height_reg <= 6'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gaps_pkg::CFG_START_COL:   start_col_reg   <= cfg_data[4:0];
                gaps_pkg::CFG_START_ROW:   start_row_reg   <= cfg_data[4:0];
                gaps_pkg::CFG_GOAL_COL:    goal_col_reg    <= cfg_data[4:0];
                gaps_pkg::CFG_GOAL_ROW:    goal_row_reg    <= cfg_data[4:0];
                gaps_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                gaps_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        g_reg          <= g_next;
        cur_col_reg    <= cur_col_next;
        cur_row_reg    <= cur_row_next;
        best_k_reg     <= best_k_next;
        best_score_reg <= best_score_next;
        best_col_reg   <= best_col_next;
        best_row_reg   <= best_row_next;
        item_reg       <= item_next;
        if (out_load)
            out_reg <= out_next;
    end

    // Cell memory: marks, cost, parent and passable bit per cell
    always_ff @(posedge clk)
    begin
        if (cm_we)
            cell_mem[cm_waddr] <= cm_wdata;
        if (cm_re)
            cm_rdata_reg <= cell_mem[cm_raddr];
    end

    // List memory: open list during a search, path points afterwards
    always_ff @(posedge clk)
    begin
        if (lm_we)
            list_mem[lm_waddr] <= lm_wdata;
        if (lm_re)
            lm_rdata_reg <= list_mem[lm_raddr];
    end

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && out_stall))
        else $error("result overwrites a word still held");

    assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) <= NC)
        else $error("open list count beyond storage");

    assert property (@(posedge clk) disable iff (!rst_n)
        int'(len_reg) <= NC)
        else $error("path length beyond storage");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(cm_we && cm_re && cm_waddr == cm_raddr))
        else $error("cell memory read and write collide");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_next.status == gaps_pkg::ST_FOUND |-> out_next.point_count != '0)
        else $error("path found with no points");

endmodule

`default_nettype wire

// File: tb/gaps_checker.sv
`default_nettype none

module gaps_checker (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    input  wire                                in_stall,
    input  gaps_pkg::in_word_t                 in_data,
    input  wire                                out_valid,
    input  wire                                out_stall,
    input  gaps_pkg::out_word_t                out_data,
    input  wire                                cfg_valid,
    input  wire                                cfg_ready,
    input  wire [gaps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [gaps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 fails,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = gaps_pkg::MAX_COLS_DEF;
    localparam int ROWS  = gaps_pkg::MAX_ROWS_DEF;
    localparam int CELLS = COLS * ROWS;

    // Shadow registers
    int start_c, start_r, goal_c, goal_r, width_raw, height_raw;

    // Shadow grid and search state
    bit walkable [CELLS];
    bit closed   [CELLS];
    bit in_open  [CELLS];
    int cost     [CELLS];
    int par_c    [CELLS];
    int par_r    [CELLS];
    int open_cell  [CELLS];
    int open_score [CELLS];
    int open_len;
    int path_c [CELLS+1];
    int path_r [CELLS+1];
    int path_len;

    gaps_pkg::out_word_t result_q [$];

    function automatic int clamp_dim(int v, int max_v);
        if (v == 0)
            return 1;
        return (v > max_v) ? max_v : v;
    endfunction

    function automatic int dist_to_goal(int c, int r);
        int dc;
        int dr;
        dc = (c > goal_c) ? c - goal_c : goal_c - c;
        dr = (r > goal_r) ? r - goal_r : goal_r - r;
        return (dc + dr) >> 1;
    endfunction

    // Push or relax the four neighbors: left, right, up, down with wrap
    function automatic void open_neighbors(int c, int r, int g, int w, int h);
        int nc;
        int nr;
        int idx;
        int ng;
        for (int d = 0; d < 4; d++)
        begin
            nc = c;
            nr = r;
            case (d)
                0: nc--;
                1: nc++;
                2: nr--;
                default: nr++;
            endcase
            if (nc < 0) nc = w - 1;
            if (nr < 0) nr = h - 1;
            if (nc >= w) nc = 0;
            if (nr >= h) nr = 0;
            idx = nr * COLS + nc;
            if (!walkable[idx] || closed[idx])
                continue;
            ng = g + 1;
            if (!in_open[idx])
            begin
                if (open_len >= CELLS)
                    continue;
                in_open[idx] = 1;
                par_c[idx] = c;
                par_r[idx] = r;
                cost[idx] = ng;
                open_cell[open_len] = idx;
                open_score[open_len] = ng + dist_to_goal(nc, nr);
                open_len++;
            end
            else if (ng < cost[idx])
            begin
                par_c[idx] = c;
                par_r[idx] = r;
                cost[idx] = ng;
                for (int k = 0; k < open_len; k++)
                    if (open_cell[k] == idx)
                        open_score[k] = ng + dist_to_goal(nc, nr);
            end
        end
    endfunction

    // Walk parents back from the goal, then store the path start first
    function automatic void trace_path();
        int tc [CELLS+1];
        int tr [CELLS+1];
        int n;
        int col;
        int row;
        n = 0;
        col = goal_c;
        row = goal_r;
        while (n < CELLS + 1)
        begin
            tc[n] = col;
            tr[n] = row;
            n++;
            if (col == start_c && row == start_r)
                break;
            col = par_c[row * COLS + tc[n-1]];
            row = par_r[row * COLS + tc[n-1]];
        end
        for (int i = 0; i < n; i++)
        begin
            path_c[i] = tc[n-1-i];
            path_r[i] = tr[n-1-i];
        end
        path_len = n;
    endfunction

    function automatic bit run_search();
        int w;
        int h;
        int best;
        int idx;
        int col;
        int row;
        w = clamp_dim(width_raw, COLS);
        h = clamp_dim(height_raw, ROWS);
        closed = '{default: 0};
        in_open = '{default: 0};
        open_len = 0;
        path_len = 0;
        if (start_c == goal_c && start_r == goal_r)
            return 0;
        if (start_c < w && start_r < h)
            closed[start_r * COLS + start_c] = 1;
        open_neighbors(start_c, start_r, 0, w, h);
        while (open_len > 0)
        begin
            best = 0;
            for (int k = 1; k < open_len; k++)
                if (open_score[k] < open_score[best])
                    best = k;
            idx = open_cell[best];
            col = idx % COLS;
            row = idx / COLS;
            if (col == goal_c && row == goal_r)
            begin
                trace_path();
                return 1;
            end
            for (int k = best; k < open_len - 1; k++)
            begin
                open_cell[k] = open_cell[k+1];
                open_score[k] = open_score[k+1];
            end
            open_len--;
            in_open[idx] = 0;
            closed[idx] = 1;
            open_neighbors(col, row, cost[idx], w, h);
        end
        return 0;
    endfunction

    task automatic report(string what, int got, int want);
        if (fails < 50)
            $display("mismatch on %s at %0t: got %0d, want %0d",
                     what, $realtime, got, want);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gaps_pkg::out_word_t want;
        gaps_pkg::out_word_t got;
        if (!rst_n)
        begin
            start_c = 0;
            start_r = 0;
            goal_c = 0;
            goal_r = 0;
            width_raw = 32;
            height_raw = 32;
            walkable = '{default: 0};
            open_len = 0;
            path_len = 0;
            result_q.delete();
            fails = 0;
            pending <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gaps_pkg::CFG_START_COL:   start_c = int'(cfg_data) & 31;
                    gaps_pkg::CFG_START_ROW:   start_r = int'(cfg_data) & 31;
                    gaps_pkg::CFG_GOAL_COL:    goal_c = int'(cfg_data) & 31;
                    gaps_pkg::CFG_GOAL_ROW:    goal_r = int'(cfg_data) & 31;
                    gaps_pkg::CFG_GRID_WIDTH:  width_raw = int'(cfg_data);
                    gaps_pkg::CFG_GRID_HEIGHT: height_raw = int'(cfg_data);
                    default: ;
                endcase
            end

            // Predict the result of an accepted word
            if (in_valid && !in_stall)
            begin
                want = '0;
                case (in_data.mode)
                    gaps_pkg::MODE_WRITE:
                    begin
                        walkable[int'(in_data.cell_row) * COLS + int'(in_data.cell_col)] =
                            in_data.passable;
                        want.status = gaps_pkg::ST_WRITTEN;
                        result_q = {result_q, want};
                    end
                    gaps_pkg::MODE_SEARCH:
                    begin
                        want.status = run_search() ? gaps_pkg::ST_FOUND : gaps_pkg::ST_NOPATH;
                        want.point_count = 11'(path_len);
                        result_q = {result_q, want};
                    end
                    gaps_pkg::MODE_READ:
                    begin
                        want.point_count = 11'(path_len);
                        if (int'(in_data.point_index) < path_len)
                        begin
                            want.status = gaps_pkg::ST_POINT;
                            want.point_col = 5'(path_c[in_data.point_index]);
                            want.point_row = 5'(path_r[in_data.point_index]);
                        end
                        else
                            want.status = gaps_pkg::ST_RANGE;
                        result_q = {result_q, want};
                    end
                    default: ;
                endcase
            end

            // Compare an accepted result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (result_q.size() == 0)
                    report("unexpected result word", got.status, -1);
                else
                begin
                    want = result_q.pop_front();
                    if (got.status != want.status)
                        report("status", got.status, want.status);
                    if (got.point_count != want.point_count)
                        report("point_count", got.point_count, want.point_count);
                    if (got.point_col != want.point_col)
                        report("point_col", got.point_col, want.point_col);
                    if (got.point_row != want.point_row)
                        report("point_row", got.point_row, want.point_row);
                end
            end
            pending <= result_q.size();
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000000;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    gaps_pkg::in_word_t              in_data;
    logic                            out_valid;
    logic                            out_stall;
    gaps_pkg::out_word_t             out_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [gaps_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gaps_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              fails;
    int                              pending;

    int quiet_cycles;
    int burst_left;
    int use_w;
    int use_h;
    int stall_pct;
    int stall_hold;

    grid_astar_path_search_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gaps_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Stall the result side in changing patterns
    initial
    begin
        out_stall = 0;
        stall_hold = 0;
        stall_pct = 0;
        forever
        begin
            @(posedge clk);
            if (stall_hold == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 30;
                    3: stall_pct = 70;
                    default: stall_pct = 95;
                endcase
                stall_hold = $urandom_range(10, 200);
            end
            stall_hold--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // End the run when nothing moves for too long
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Write all six registers; the caller's block must be idle
    task automatic set_regs(int sc, int sr, int gc, int gr, int w, int h);
        int vals [6];
        vals = '{sc, sr, gc, gr, w, h};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1;
            cfg_index <= i[gaps_pkg::CFG_IDX_W-1:0];
            cfg_data <= vals[i][gaps_pkg::CFG_DATA_W-1:0];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 0;
        use_w = (w == 0) ? 1 : (w > 32 ? 32 : w);
        use_h = (h == 0) ? 1 : (h > 32 ? 32 : h);
    endtask

    // Send one word, then maybe close the burst with a gap
    task automatic send(gaps_pkg::in_word_t w);
        int gap;
        in_valid <= 1;
        in_data <= w;
        do @(posedge clk); while (in_stall);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic gaps_pkg::in_word_t make_word(logic [1:0] m, int c, int r, int p,
                                                     int idx);
        gaps_pkg::in_word_t w;
        w.mode = m;
        w.cell_col = 5'((c >= 0) ? c : $urandom_range(0, 31));
        w.cell_row = 5'((r >= 0) ? r : $urandom_range(0, 31));
        w.passable = 1'((p >= 0) ? p : $urandom_range(0, 1));
        w.point_index = 10'((idx >= 0) ? idx : $urandom_range(0, 1023));
        return w;
    endfunction

    function automatic gaps_pkg::in_word_t random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            if ($urandom_range(0, 9) == 0)
                return make_word(gaps_pkg::MODE_WRITE, -1, -1, -1, -1);
            return make_word(gaps_pkg::MODE_WRITE, $urandom_range(0, use_w - 1),
                             $urandom_range(0, use_h - 1), $urandom_range(0, 3) != 0, -1);
        end
        if (pick < 70)
            return make_word(gaps_pkg::MODE_SEARCH, -1, -1, -1, -1);
        if (pick < 97)
            return make_word(gaps_pkg::MODE_READ, -1, -1, -1,
                             ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40) : -1);
        return make_word(gaps_pkg::MODE_UNUSED, -1, -1, -1, -1);
    endfunction

    function automatic int pick_dim();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(2, 8);
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return 32;
            3: return 63;
            default: return $urandom_range(0, 63);
        endcase
    endfunction

    function automatic int pick_pos(int lim);
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, lim - 1);
        return $urandom_range(0, 63);
    endfunction

    initial
    begin
        int w;
        int h;
        int sc;
        int sr;
        int sent;
        gaps_pkg::in_word_t word;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // Directed: open 3x3 grid, one blocked cell, corner to corner
        set_regs(0, 0, 2, 2, 3, 3);
        send(make_word(gaps_pkg::MODE_WRITE, 31, 31, 1, 0));
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send(make_word(gaps_pkg::MODE_WRITE, c, r, 1, 1023));
        send(make_word(gaps_pkg::MODE_WRITE, 1, 1, 0, 0));
        send(make_word(gaps_pkg::MODE_SEARCH, 0, 0, 0, 0));
        send(make_word(gaps_pkg::MODE_READ, 0, 0, 0, 0));
        send(make_word(gaps_pkg::MODE_READ, 0, 0, 0, 2));
        send(make_word(gaps_pkg::MODE_READ, 0, 0, 0, 3));
        send(make_word(gaps_pkg::MODE_READ, 31, 31, 1, 1023));
        send(make_word(gaps_pkg::MODE_UNUSED, 31, 31, 1, 1023));
        drain();

        // Directed: start equals goal, clamped grid sizes
        set_regs(1, 1, 1, 1, 0, 63);
        send(make_word(gaps_pkg::MODE_SEARCH, 0, 0, 0, 0));
        send(make_word(gaps_pkg::MODE_READ, 0, 0, 0, 0));
        drain();

        // Directed: start outside the grid, goal outside the grid
        set_regs(20, 0, 1, 0, 3, 3);
        send(make_word(gaps_pkg::MODE_SEARCH, 0, 0, 0, 0));
        send(make_word(gaps_pkg::MODE_READ, 0, 0, 0, 1));
        drain();
        set_regs(0, 0, 31, 31, 3, 3);
        send(make_word(gaps_pkg::MODE_SEARCH, 0, 0, 0, 0));
        drain();

        // Random phases: fresh registers, then writes, searches and reads
        for (int phase = 0; phase < 40; phase++)
        begin
            w = pick_dim();
            h = pick_dim();
            use_w = (w == 0) ? 1 : (w > 32 ? 32 : w);
            use_h = (h == 0) ? 1 : (h > 32 ? 32 : h);
            sc = pick_pos(use_w);
            sr = pick_pos(use_h);
            if ($urandom_range(0, 9) == 0)
                set_regs(sc, sr, sc, sr, w, h);
            else
                set_regs(sc, sr, pick_pos(use_w), pick_pos(use_h), w, h);
            sent = 0;
            while (sent < 40)
            begin
                word = random_word();
                send(word);
                if (word.mode != gaps_pkg::MODE_UNUSED)
                    sent++;
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/gaps_pkg.sv
rtl/grid_astar_path_search_top.sv
tb/gaps_checker.sv
tb/tb_top.sv
